### rtl/lbsc_pkg.sv
package lbsc_pkg;

	localparam int NUM_FACES = 6;
	localparam int FRAC_BITS = 16;
	localparam int NUM_W     = 33;
	localparam int DIV_STEPS = NUM_W + FRAC_BITS;
	localparam int CMP_W     = DIV_STEPS + 2;

	localparam logic [31:0] CODE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] CODE_MIN = 32'h8000_0000;

	localparam logic [2:0] REG_BOX_LO_X = 3'd0;
	localparam logic [2:0] REG_BOX_LO_Y = 3'd1;
	localparam logic [2:0] REG_BOX_LO_Z = 3'd2;
	localparam logic [2:0] REG_BOX_HI_X = 3'd3;
	localparam logic [2:0] REG_BOX_HI_Y = 3'd4;
	localparam logic [2:0] REG_BOX_HI_Z = 3'd5;

	typedef struct packed {
		logic [31:0]          rem;
		logic [DIV_STEPS-1:0] dq;
		logic [31:0]          dvs;
		logic                 d_pos;
		logic                 d_neg;
		logic                 n_pos;
		logic                 n_neg;
	} face_t;

	typedef struct packed {
		logic        pass;
		logic        t0_inf;
		logic        t1_inf;
		logic [31:0] t0;
		logic [31:0] t1;
	} bnd_t;

	function automatic face_t mk_face(input logic [NUM_W-1:0] n, input logic [NUM_W-1:0] d);
		face_t f;
		logic [NUM_W-1:0] an;
		logic [NUM_W-1:0] ad;
		an = n[NUM_W-1] ? (~n + 1'b1) : n;
		ad = d[NUM_W-1] ? (~d + 1'b1) : d;
		f.rem   = '0;
		f.dq    = {an, {FRAC_BITS{1'b0}}};
		f.dvs   = ad[31:0];
		f.d_neg = d[NUM_W-1];
		f.d_pos = !d[NUM_W-1] && (|d);
		f.n_neg = n[NUM_W-1];
		f.n_pos = !n[NUM_W-1] && (|n);
		return f;
	endfunction

endpackage

### rtl/lbsc_if.sv
interface lbsc_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] dir_x;
	logic [31:0] dir_y;
	logic [31:0] dir_z;
	modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface lbsc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] t_enter;
	logic [31:0] t_exit;
	modport source (output valid, hit, t_enter, t_exit, input ready);
	modport sink   (input valid, hit, t_enter, t_exit, output ready);
endinterface

### rtl/lbsc_div_cell.sv
module lbsc_div_cell (
	input  logic          clk,
	input  logic          en,
	input  lbsc_pkg::face_t d_in,
	output lbsc_pkg::face_t d_q
);
	import lbsc_pkg::*;

	logic [32:0] sh;
	logic [33:0] diff;
	face_t       nxt;

	always_comb begin
		nxt  = d_in;
		sh   = {d_in.rem, d_in.dq[DIV_STEPS-1]};
		diff = {1'b0, sh} - {2'b00, d_in.dvs};
		if (!diff[33]) begin
			nxt.rem = diff[31:0];
			nxt.dq  = {d_in.dq[DIV_STEPS-2:0], 1'b1};
		end else begin
			nxt.rem = sh[31:0];
			nxt.dq  = {d_in.dq[DIV_STEPS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end
endmodule

### rtl/lbsc_face_cell.sv
module lbsc_face_cell (
	input  logic          clk,
	input  logic          en,
	input  lbsc_pkg::face_t f,
	input  lbsc_pkg::bnd_t  b_in,
	output lbsc_pkg::bnd_t  b_q
);
	import lbsc_pkg::*;

	logic              neg, rz;
	logic signed [CMP_W-1:0] q, fl, ce, tr, t0e, t1e;
	logic [31:0]       sat;
	logic              gt0, gt1, lt0, lt1;
	bnd_t              nxt;

	always_comb begin
		neg = f.n_neg ^ f.d_neg;
		rz  = |f.rem;
		q   = $signed({2'b00, f.dq});
		fl  = neg ? (-q - $signed({{(CMP_W-1){1'b0}}, rz})) : q;
		ce  = neg ? -q : (q + $signed({{(CMP_W-1){1'b0}}, rz}));
		tr  = neg ? -q : q;
		if (tr > $signed({{(CMP_W-32){1'b0}}, CODE_MAX}))
			sat = CODE_MAX;
		else if (tr < $signed({{(CMP_W-32){1'b1}}, CODE_MIN}))
			sat = CODE_MIN;
		else
			sat = tr[31:0];
		t0e = $signed({{(CMP_W-32){b_in.t0[31]}}, b_in.t0});
		t1e = $signed({{(CMP_W-32){b_in.t1[31]}}, b_in.t1});
		gt0 = (fl > t0e) || ((fl == t0e) && rz);
		gt1 = (fl > t1e) || ((fl == t1e) && rz);
		lt0 = (ce < t0e) || ((ce == t0e) && rz);
		lt1 = (ce < t1e) || ((ce == t1e) && rz);

		nxt = b_in;
		if (b_in.pass) begin
			if (f.d_pos) begin
				if (!b_in.t1_inf && gt1) begin
					nxt.pass = 1'b0;
				end else if (b_in.t0_inf || gt0) begin
					nxt.t0     = sat;
					nxt.t0_inf = 1'b0;
				end
			end else if (f.d_neg) begin
				if (!b_in.t0_inf && lt0) begin
					nxt.pass = 1'b0;
				end else if (b_in.t1_inf || lt1) begin
					nxt.t1     = sat;
					nxt.t1_inf = 1'b0;
				end
			end else if (f.n_pos) begin
				nxt.pass = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_q <= nxt;
		end
	end
endmodule

### rtl/line_box_slab_clip_unit.sv
// channel  dir  handshake     payload
// req      in   valid/ready   pos_x pos_y pos_z dir_x dir_y dir_z
// rsp      out  valid/ready   hit t_enter t_exit
// cfg      in   cfg_we        cfg_idx cfg_data
//
// One transaction per cycle sustained while rsp is ready.
// The pipe is the input register, the 49-cell quotient chain (one bit
// per cell, six lanes), six face cells and the output register.
// A stalled rsp holds the pipe; empty stages still advance, closing bubbles.
// arst_n clears valid bits and the box registers.
module line_box_slab_clip_unit (
	input  logic        clk,
	input  logic        arst_n,
	lbsc_req_if.sink    req,
	lbsc_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import lbsc_pkg::*;

	localparam int FACE_STG = DIV_STEPS + 1;
	localparam int OUT_STG  = FACE_STG + NUM_FACES;
	localparam int NSTG     = OUT_STG + 1;

	logic [31:0] box_q [NUM_FACES];
	logic [NSTG-1:0] v_q;
	logic [NSTG:0]   en;

	face_t div_s   [DIV_STEPS+1][NUM_FACES];
	face_t faces_s [NUM_FACES][NUM_FACES];
	face_t init_f  [NUM_FACES];
	bnd_t  bnd_s   [NUM_FACES];
	bnd_t  bnd_init;
	logic [31:0] pos [3];
	logic [31:0] dir [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FACES; i++) box_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BOX_LO_X: box_q[0] <= cfg_data;
				REG_BOX_LO_Y: box_q[1] <= cfg_data;
				REG_BOX_LO_Z: box_q[2] <= cfg_data;
				REG_BOX_HI_X: box_q[3] <= cfg_data;
				REG_BOX_HI_Y: box_q[4] <= cfg_data;
				REG_BOX_HI_Z: box_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		en[NSTG] = rsp.ready;
		for (int k = NSTG - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
	end
	assign req.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= req.valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign pos[0] = req.pos_x;
	assign pos[1] = req.pos_y;
	assign pos[2] = req.pos_z;
	assign dir[0] = req.dir_x;
	assign dir[1] = req.dir_y;
	assign dir[2] = req.dir_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			init_f[2*a] = mk_face(
				{box_q[a][31], box_q[a]} - {pos[a][31], pos[a]},
				{dir[a][31], dir[a]});
			init_f[2*a+1] = mk_face(
				{pos[a][31], pos[a]} - {box_q[a+3][31], box_q[a+3]},
				~{dir[a][31], dir[a]} + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NUM_FACES; i++) div_s[0][i] <= init_f[i];
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		for (genvar i = 0; i < NUM_FACES; i++) begin : g_lane
			lbsc_div_cell u_cell (
				.clk  (clk),
				.en   (en[k]),
				.d_in (div_s[k-1][i]),
				.d_q  (div_s[k][i])
			);
		end
	end

	assign faces_s[0] = div_s[DIV_STEPS];
	for (genvar k = 1; k < NUM_FACES; k++) begin : g_fpipe
		always_ff @(posedge clk) begin
			if (en[FACE_STG+k-1]) faces_s[k] <= faces_s[k-1];
		end
	end

	assign bnd_init = '{pass: 1'b1, t0_inf: 1'b1, t1_inf: 1'b1, t0: '0, t1: '0};

	for (genvar k = 0; k < NUM_FACES; k++) begin : g_face
		lbsc_face_cell u_cell (
			.clk  (clk),
			.en   (en[FACE_STG+k]),
			.f    (faces_s[k][k]),
			.b_in ((k == 0) ? bnd_init : bnd_s[(k == 0) ? 0 : k-1]),
			.b_q  (bnd_s[k])
		);
	end

	bnd_t  fb;
	logic  hit_c;
	logic        hit_s;
	logic [31:0] t_enter_s, t_exit_s;

	always_comb begin
		fb    = bnd_s[NUM_FACES-1];
		hit_c = fb.pass && (fb.t0_inf || fb.t1_inf || ($signed(fb.t1) > $signed(fb.t0)));
	end

	always_ff @(posedge clk) begin
		if (en[OUT_STG]) begin
			hit_s     <= hit_c;
			t_enter_s <= hit_c ? (fb.t0_inf ? CODE_MIN : fb.t0) : CODE_MAX;
			t_exit_s  <= hit_c ? (fb.t1_inf ? CODE_MAX : fb.t1) : CODE_MIN;
		end
	end

	assign rsp.valid   = v_q[OUT_STG];
	assign rsp.hit     = hit_s;
	assign rsp.t_enter = t_enter_s;
	assign rsp.t_exit  = t_exit_s;

	a_miss_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.t_enter == CODE_MAX && rsp.t_exit == CODE_MIN)
		else $error("miss without miss codes");

	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> $signed(rsp.t_exit) >= $signed(rsp.t_enter))
		else $error("hit with exit before entry");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (&v_q) && !rsp.ready)
		else $error("input stalled with space in pipe");
endmodule
